// ===== rtl/rcfd_pkg.sv =====
// rcfd_pkg: shared types, constants and helpers of the robot command frame decoder
// no dependencies; imported by every rtl module of the block and by its checker
package rcfd_pkg;

  // frame layout
  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
  localparam int unsigned POS_HEAD  = 0;
  localparam int unsigned POS_L1    = 1;
  localparam int unsigned POS_L2    = 2;
  localparam int unsigned POS_D0    = 3;
  localparam int unsigned POS_D1    = 4;
  localparam int unsigned POS_D2    = 5;
  localparam int unsigned POS_CR    = FRAME_LEN - 2;
  localparam int unsigned POS_LF    = FRAME_LEN - 1;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CODE_W  = 10;
  localparam int unsigned PULSE_W = 10;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned OFFS_W  = 4;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned FLAG_W  = 4;
  localparam int unsigned ACT_W   = 4;
  localparam int unsigned DIGIT_W = 4;

  // register port
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned REG_W  = 3;

  // divider sizing: dividend below 2^24, divisor below 2^18, quotient below 2^16
  localparam int unsigned DIV_N_W = 24;
  localparam int unsigned DIV_D_W = 18;
  localparam int unsigned DIV_Q_W = 16;
  localparam int unsigned DIV_C_W = $clog2(DIV_Q_W);

  // characters
  localparam logic [BYTE_W-1:0] CH_HASH = 8'd35;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'd13;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_DOT  = 8'd46;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'd48;
  localparam logic [BYTE_W-1:0] CH_NINE = 8'd57;

  localparam logic [CODE_W-1:0] DEC_TEN  = 10'd10;
  localparam logic [CODE_W-1:0] DEC_HUND = 10'd100;

  // letter sums selecting an action
  localparam logic [BYTE_W-1:0] SUM_STEP_RIGHT = 8'd150;
  localparam logic [BYTE_W-1:0] SUM_STEP_LEFT  = 8'd142;
  localparam logic [BYTE_W-1:0] SUM_STEP_CFG   = 8'd143;
  localparam logic [BYTE_W-1:0] SUM_SERVO_SET  = 8'd160;
  localparam logic [BYTE_W-1:0] SUM_SERVO_UP   = 8'd149;
  localparam logic [BYTE_W-1:0] SUM_SERVO_DN   = 8'd157;
  localparam logic [BYTE_W-1:0] SUM_DC_SET     = 8'd145;
  localparam logic [BYTE_W-1:0] SUM_DC_FWD     = 8'd138;
  localparam logic [BYTE_W-1:0] SUM_DC_BWD     = 8'd134;
  localparam logic [BYTE_W-1:0] SUM_STOP       = 8'd166;
  localparam logic [BYTE_W-1:0] SUM_TELEM      = 8'd167;
  localparam logic [BYTE_W-1:0] SUM_LIGHT      = 8'd161;
  localparam logic [BYTE_W-1:0] SUM_SUPPLY     = 8'd159;
  localparam logic [BYTE_W-1:0] SUM_CUR_LIM    = 8'd140;
  localparam logic [BYTE_W-1:0] SUM_SPD_LIM    = 8'd158;
  localparam logic [BYTE_W-1:0] SUM_OBST       = 8'd154;
  localparam logic [BYTE_W-1:0] SUM_LINK       = 8'd151;
  localparam logic [BYTE_W-1:0] SUM_RESET      = 8'd165;
  localparam logic [BYTE_W-1:0] SUM_HOST       = 8'd162;

  // host subcommand codes
  localparam logic [CODE_W-1:0] HOST_SBC_A   = 10'd111;
  localparam logic [CODE_W-1:0] HOST_SBC_B   = 10'd1;
  localparam logic [CODE_W-1:0] HOST_RADIO_A = 10'd0;
  localparam logic [CODE_W-1:0] HOST_RADIO_B = 10'd6;
  localparam logic [CODE_W-1:0] LIGHT_ON     = 10'd1;

  // limit conversions as exact rationals
  localparam logic [DIV_N_W-1:0] CUR_SCALE   = 24'd12288;
  localparam logic [DIV_N_W-1:0] OBST_SCALE  = 24'd8192;
  localparam logic [DIV_D_W-1:0] CONV_DIV    = 18'd671;
  localparam logic [DIV_N_W-1:0] SPEED_NUM   = 24'd576000;
  localparam logic [DIV_D_W-1:0] SPEED_SCALE = 18'd205;

  // reset values
  localparam logic [PULSE_W-1:0] RST_SERVO_LO  = 10'd105;
  localparam logic [PULSE_W-1:0] RST_SERVO_HI  = 10'd175;
  localparam logic [STEP_W-1:0]  RST_SERVO_STP = 6'd5;
  localparam logic [PULSE_W-1:0] RST_DC_NEU    = 10'd50;
  localparam logic [PULSE_W-1:0] RST_DC_FWD    = 10'd40;
  localparam logic [PULSE_W-1:0] RST_DC_BWD    = 10'd60;
  localparam logic [OFFS_W-1:0]  RST_DC_OFFS   = 4'd3;
  localparam logic [PULSE_W-1:0] RST_SERVO     = 10'd140;
  localparam logic [PULSE_W-1:0] RST_DC_PULSE  = 10'd50;

  typedef enum logic [REG_W-1:0] {
    REG_SERVO_LO  = 3'd0,
    REG_SERVO_HI  = 3'd1,
    REG_SERVO_STP = 3'd2,
    REG_DC_NEU    = 3'd3,
    REG_DC_FWD    = 3'd4,
    REG_DC_BWD    = 3'd5,
    REG_DC_OFFS   = 3'd6
  } rcfd_reg_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE       = 4'd0,
    ACT_STEP_MOVE  = 4'd1,
    ACT_STEP_BUSY  = 4'd2,
    ACT_STEP_CFG   = 4'd3,
    ACT_SERVO      = 4'd4,
    ACT_DC         = 4'd5,
    ACT_STOP       = 4'd6,
    ACT_TELEM      = 4'd7,
    ACT_LIGHT      = 4'd8,
    ACT_SUPPLY     = 4'd9,
    ACT_CUR_LIM    = 4'd10,
    ACT_SPD_LIM    = 4'd11,
    ACT_OBST       = 4'd12,
    ACT_LINK       = 4'd13,
    ACT_RESET      = 4'd14,
    ACT_HOST       = 4'd15
  } rcfd_action_e;

  typedef struct packed {
    logic [PULSE_W-1:0] servo_lo;
    logic [PULSE_W-1:0] servo_hi;
    logic [STEP_W-1:0]  servo_step;
    logic [PULSE_W-1:0] dc_neutral;
    logic [PULSE_W-1:0] dc_fwd;
    logic [PULSE_W-1:0] dc_bwd;
    logic [OFFS_W-1:0]  dc_offset;
  } rcfd_cfg_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } rcfd_div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
  } rcfd_div_rsp_t;

  // ascii digit value, non-digits count as zero
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] t;
    t = c - CH_ZERO;
    return (c >= CH_ZERO && c <= CH_NINE) ? t[DIGIT_W-1:0] : '0;
  endfunction

endpackage

// ===== rtl/robot_command_frame_decoder.sv =====
// robot_command_frame_decoder: top level, byte collection, frame decode and action sequencer
// depends on rcfd_pkg, rcfd_cfg (register bank) and rcfd_div (shared divider)
//
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+-----------------------------------------
// in       | input     | in_valid_i / in_ready_o | mode_i, rx_byte_i
// out      | output    | out_valid_o/out_ready_i | frame_ok_o, action_o, code_value_o, ...
// cfg      | input     | psel, penable, pwrite   | paddr, pwdata, prdata (pready tied high)
//
// a byte that does not close a frame, and a stepper-done item, are taken in the idle state
// a closing byte passes decode, execute and output states, plus a divide state when a limit
//   conversion runs: it goes through the shared divider at one quotient bit per cycle
// in_ready_o is low while a frame is processed, and before a closing byte
//   while the previous result has not been taken yet
// reset clears the byte counter and the actuator state; stored frame bytes are
//   not cleared since every byte is written before it is read
module robot_command_frame_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic [7:0]                  rx_byte_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        frame_ok_o,
  output logic [3:0]                  action_o,
  output logic [9:0]                  code_value_o,
  output logic                        stepper_direction_o,
  output logic [9:0]                  servo_pulse_out_o,
  output logic [9:0]                  dc_pulse_out_o,
  output logic                        dc_enable_out_o,
  output logic [15:0]                 current_limit_out_o,
  output logic [15:0]                 speed_limit_out_o,
  output logic [15:0]                 obstacle_level_out_o,
  output logic                        radio_link_out_o,
  output logic [3:0]                  status_flags_o,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcfd_pkg::ADDR_W-1:0] paddr,
  input  logic [rcfd_pkg::DATA_W-1:0] pwdata,
  output logic [rcfd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import rcfd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_DIV,
    S_OUT
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  rcfd_cfg_t     cfg;
  rcfd_div_req_t div_req;
  rcfd_div_rsp_t div_rsp;

  state_e              state_q;
  logic [IDX_W-1:0]    byte_idx_q;
  logic [BYTE_W-1:0]   frame_q [FRAME_LEN];

  // decoded frame
  logic                ok_q;
  logic [BYTE_W-1:0]   sum_q;
  logic [CODE_W-1:0]   code_q;
  rcfd_action_e        act_q;
  logic                dir_q;

  // actuator and limit state
  logic [PULSE_W-1:0]  servo_q;
  logic [PULSE_W-1:0]  dc_pulse_q;
  logic                dc_en_q;
  logic                busy_q;
  logic                telem_q;
  logic                light_q;
  logic                supply_q;
  logic                radio_q;
  logic [LIMIT_W-1:0]  cur_lim_q;
  logic [LIMIT_W-1:0]  spd_lim_q;
  logic [LIMIT_W-1:0]  obst_q;

  // output register
  logic                out_valid_q;
  logic                o_ok_q;
  rcfd_action_e        o_act_q;
  logic [CODE_W-1:0]   o_code_q;
  logic                o_dir_q;
  logic [PULSE_W-1:0]  o_servo_q;
  logic [PULSE_W-1:0]  o_dc_q;
  logic                o_dc_en_q;
  logic [LIMIT_W-1:0]  o_cur_q;
  logic [LIMIT_W-1:0]  o_spd_q;
  logic [LIMIT_W-1:0]  o_obst_q;
  logic                o_radio_q;
  logic [FLAG_W-1:0]   o_flags_q;

  logic                in_fire;
  logic                out_fire;

  // decode logic
  logic [DIGIT_W-1:0]  dig0, dig1, dig2;
  logic [CODE_W-1:0]   code_two, code_three;
  logic                head_ok;

  // servo step
  logic [PULSE_W:0]    servo_up;
  logic signed [PULSE_W+1:0] servo_dn;

  // dc step
  logic                      dc_fwd;
  logic signed [PULSE_W+1:0] dc_cur_s, dc_neu_s, dc_off_s, dc_try_s, dc_new_s;
  logic                      dc_hit;

  rcfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rcfd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // a closing byte waits until the last result has been taken
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || byte_idx_q != LAST_IDX);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_fire   = out_valid_q & out_ready_i;

  // frame decode from the stored bytes
  always_comb begin
    dig0       = digit_of(frame_q[POS_D0]);
    dig1       = digit_of(frame_q[POS_D1]);
    dig2       = digit_of(frame_q[POS_D2]);
    code_two   = CODE_W'(dig0) * DEC_TEN + CODE_W'(dig2);
    code_three = CODE_W'(dig0) * DEC_HUND + CODE_W'(dig1) * DEC_TEN + CODE_W'(dig2);
    head_ok    = (frame_q[POS_HEAD] == CH_HASH) && (frame_q[POS_CR] == CH_CR)
              && (frame_q[POS_LF] == CH_LF);
  end

  // servo stepping at full precision before clamping
  assign servo_up = {1'b0, servo_q} + (PULSE_W + 1)'(cfg.servo_step);
  assign servo_dn = $signed({2'b00, servo_q}) - $signed((PULSE_W + 2)'(cfg.servo_step));

  // dc stepping: first step off neutral jumps by the start offset
  always_comb begin
    dc_fwd   = (sum_q == SUM_DC_FWD);
    dc_cur_s = $signed({2'b00, dc_pulse_q});
    dc_neu_s = $signed({2'b00, cfg.dc_neutral});
    dc_off_s = $signed((PULSE_W + 2)'(cfg.dc_offset));
    if (dc_cur_s == dc_neu_s) begin
      dc_try_s = dc_fwd ? dc_neu_s - dc_off_s : dc_neu_s + dc_off_s;
    end else begin
      dc_try_s = dc_fwd ? dc_cur_s - 12'sd1 : dc_cur_s + 12'sd1;
    end
    dc_hit   = (dc_try_s == dc_neu_s);
    dc_new_s = dc_try_s;
    if (!dc_hit) begin
      if (dc_fwd && dc_try_s < $signed({2'b00, cfg.dc_fwd})) begin
        dc_new_s = $signed({2'b00, cfg.dc_fwd});
      end
      if (!dc_fwd && dc_try_s > $signed({2'b00, cfg.dc_bwd})) begin
        dc_new_s = $signed({2'b00, cfg.dc_bwd});
      end
    end
  end

  // limit conversions share the divider; a zero speed code saturates instead
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = SPEED_NUM;
    div_req.divisor  = DIV_D_W'(code_q) * SPEED_SCALE;
    if (state_q == S_EXEC && ok_q) begin
      priority if (sum_q == SUM_CUR_LIM) begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_N_W'(code_q) * CUR_SCALE;
        div_req.divisor  = CONV_DIV;
      end else if (sum_q == SUM_OBST) begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_N_W'(code_q) * OBST_SCALE;
        div_req.divisor  = CONV_DIV;
      end else if (sum_q == SUM_SPD_LIM && code_q != '0) begin
        div_req.start    = 1'b1;
      end else begin
        div_req.start    = 1'b0;
      end
    end
  end

  // frame byte store, written before it is ever read
  always_ff @(posedge clk_i) begin
    if (in_fire && !mode_i) begin
      frame_q[byte_idx_q] <= rx_byte_i;
    end
  end

  // sequencer with actuator state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      byte_idx_q  <= '0;
      ok_q        <= 1'b0;
      sum_q       <= '0;
      code_q      <= '0;
      act_q       <= ACT_NONE;
      dir_q       <= 1'b0;
      servo_q     <= RST_SERVO;
      dc_pulse_q  <= RST_DC_PULSE;
      dc_en_q     <= 1'b0;
      busy_q      <= 1'b0;
      telem_q     <= 1'b0;
      light_q     <= 1'b0;
      supply_q    <= 1'b0;
      radio_q     <= 1'b1;
      cur_lim_q   <= '0;
      spd_lim_q   <= '0;
      obst_q      <= '0;
      out_valid_q <= 1'b0;
      o_ok_q      <= 1'b0;
      o_act_q     <= ACT_NONE;
      o_code_q    <= '0;
      o_dir_q     <= 1'b0;
      o_servo_q   <= '0;
      o_dc_q      <= '0;
      o_dc_en_q   <= 1'b0;
      o_cur_q     <= '0;
      o_spd_q     <= '0;
      o_obst_q    <= '0;
      o_radio_q   <= 1'b0;
      o_flags_q   <= '0;
    end else begin
      if (out_fire) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (mode_i) begin
              // stepper finished its move
              busy_q <= 1'b0;
            end else begin
              byte_idx_q <= IDX_W'(byte_idx_q + 1'b1);
              if (byte_idx_q == LAST_IDX) begin
                state_q <= S_DECODE;
              end
            end
          end
        end

        S_DECODE: begin
          ok_q    <= head_ok;
          sum_q   <= frame_q[POS_L1] + frame_q[POS_L2];
          code_q  <= !head_ok ? '0 : (frame_q[POS_D1] == CH_DOT) ? code_two : code_three;
          state_q <= S_EXEC;
        end

        S_EXEC: begin
          act_q   <= ACT_NONE;
          dir_q   <= 1'b0;
          state_q <= div_req.start ? S_DIV : S_OUT;
          if (ok_q) begin
            unique case (sum_q)
              SUM_STEP_RIGHT, SUM_STEP_LEFT: begin
                if (!busy_q) begin
                  busy_q <= 1'b1;
                  act_q  <= ACT_STEP_MOVE;
                  dir_q  <= (sum_q == SUM_STEP_RIGHT);
                end else begin
                  act_q <= ACT_STEP_BUSY;
                end
              end
              SUM_STEP_CFG: act_q <= ACT_STEP_CFG;
              SUM_SERVO_SET: begin
                servo_q <= code_q;
                act_q   <= ACT_SERVO;
              end
              SUM_SERVO_UP: begin
                servo_q <= (servo_up > {1'b0, cfg.servo_hi}) ? cfg.servo_hi
                                                             : servo_up[PULSE_W-1:0];
                act_q   <= ACT_SERVO;
              end
              SUM_SERVO_DN: begin
                servo_q <= (servo_dn < $signed({2'b00, cfg.servo_lo})) ? cfg.servo_lo
                                                                      : servo_dn[PULSE_W-1:0];
                act_q   <= ACT_SERVO;
              end
              SUM_DC_SET: begin
                dc_pulse_q <= code_q;
                dc_en_q    <= (code_q != cfg.dc_neutral);
                act_q      <= ACT_DC;
              end
              SUM_DC_FWD, SUM_DC_BWD: begin
                dc_pulse_q <= dc_new_s[PULSE_W-1:0];
                dc_en_q    <= !dc_hit;
                act_q      <= ACT_DC;
              end
              SUM_STOP: act_q <= ACT_STOP;
              SUM_TELEM: begin
                telem_q <= (code_q != '0);
                act_q   <= ACT_TELEM;
              end
              SUM_LIGHT: begin
                light_q <= (code_q == LIGHT_ON);
                act_q   <= ACT_LIGHT;
              end
              SUM_SUPPLY: begin
                supply_q <= (code_q != '0);
                act_q    <= ACT_SUPPLY;
              end
              SUM_CUR_LIM: act_q <= ACT_CUR_LIM;
              SUM_SPD_LIM: begin
                if (code_q == '0) begin
                  spd_lim_q <= '1;
                end
                act_q <= ACT_SPD_LIM;
              end
              SUM_OBST: act_q <= ACT_OBST;
              SUM_LINK: begin
                radio_q <= (code_q != '0);
                act_q   <= ACT_LINK;
              end
              SUM_RESET: act_q <= ACT_RESET;
              SUM_HOST: begin
                if (code_q == HOST_SBC_A || code_q == HOST_SBC_B) begin
                  radio_q <= 1'b0;
                end else if (code_q == HOST_RADIO_A || code_q == HOST_RADIO_B) begin
                  radio_q <= 1'b1;
                end
                act_q <= ACT_HOST;
              end
              default: ;
            endcase
          end
        end

        S_DIV: begin
          if (div_rsp.done) begin
            unique case (act_q)
              ACT_CUR_LIM: cur_lim_q <= div_rsp.quotient;
              ACT_OBST:    obst_q    <= div_rsp.quotient;
              default:     spd_lim_q <= div_rsp.quotient;
            endcase
            state_q <= S_OUT;
          end
        end

        S_OUT: begin
          // output register is free: the closing byte waited for it
          out_valid_q <= 1'b1;
          o_ok_q      <= ok_q;
          o_act_q     <= act_q;
          o_code_q    <= code_q;
          o_dir_q     <= dir_q;
          o_servo_q   <= servo_q;
          o_dc_q      <= dc_pulse_q;
          o_dc_en_q   <= dc_en_q;
          o_cur_q     <= cur_lim_q;
          o_spd_q     <= spd_lim_q;
          o_obst_q    <= obst_q;
          o_radio_q   <= radio_q;
          o_flags_q   <= {busy_q, supply_q, light_q, telem_q};
          state_q     <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o          = out_valid_q;
  assign frame_ok_o           = o_ok_q;
  assign action_o             = o_act_q;
  assign code_value_o         = o_code_q;
  assign stepper_direction_o  = o_dir_q;
  assign servo_pulse_out_o    = o_servo_q;
  assign dc_pulse_out_o       = o_dc_q;
  assign dc_enable_out_o      = o_dc_en_q;
  assign current_limit_out_o  = o_cur_q;
  assign speed_limit_out_o    = o_spd_q;
  assign obstacle_level_out_o = o_obst_q;
  assign radio_link_out_o     = o_radio_q;
  assign status_flags_o       = o_flags_q;

endmodule

// ===== rtl/rcfd_cfg.sv =====
// rcfd_cfg: register bank of the frame decoder behind its register port
// depends on rcfd_pkg
module rcfd_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcfd_pkg::ADDR_W-1:0] paddr,
  input  logic [rcfd_pkg::DATA_W-1:0] pwdata,
  output logic [rcfd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output rcfd_pkg::rcfd_cfg_t        cfg_o
);
  import rcfd_pkg::*;

  rcfd_cfg_t cfg_q;
  rcfd_reg_e reg_idx;
  logic      wr_en;

  assign reg_idx = rcfd_reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.servo_lo   <= RST_SERVO_LO;
      cfg_q.servo_hi   <= RST_SERVO_HI;
      cfg_q.servo_step <= RST_SERVO_STP;
      cfg_q.dc_neutral <= RST_DC_NEU;
      cfg_q.dc_fwd     <= RST_DC_FWD;
      cfg_q.dc_bwd     <= RST_DC_BWD;
      cfg_q.dc_offset  <= RST_DC_OFFS;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SERVO_LO:  cfg_q.servo_lo   <= pwdata[PULSE_W-1:0];
        REG_SERVO_HI:  cfg_q.servo_hi   <= pwdata[PULSE_W-1:0];
        REG_SERVO_STP: cfg_q.servo_step <= pwdata[STEP_W-1:0];
        REG_DC_NEU:    cfg_q.dc_neutral <= pwdata[PULSE_W-1:0];
        REG_DC_FWD:    cfg_q.dc_fwd     <= pwdata[PULSE_W-1:0];
        REG_DC_BWD:    cfg_q.dc_bwd     <= pwdata[PULSE_W-1:0];
        REG_DC_OFFS:   cfg_q.dc_offset  <= pwdata[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SERVO_LO:  prdata = DATA_W'(cfg_q.servo_lo);
      REG_SERVO_HI:  prdata = DATA_W'(cfg_q.servo_hi);
      REG_SERVO_STP: prdata = DATA_W'(cfg_q.servo_step);
      REG_DC_NEU:    prdata = DATA_W'(cfg_q.dc_neutral);
      REG_DC_FWD:    prdata = DATA_W'(cfg_q.dc_fwd);
      REG_DC_BWD:    prdata = DATA_W'(cfg_q.dc_bwd);
      REG_DC_OFFS:   prdata = DATA_W'(cfg_q.dc_offset);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/rcfd_div.sv =====
// rcfd_div: shared restoring divider, one quotient bit per cycle
// depends on rcfd_pkg; dividend upper byte must stay below the divisor
module rcfd_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rcfd_pkg::rcfd_div_req_t req_i,
  output rcfd_pkg::rcfd_div_rsp_t rsp_o
);
  import rcfd_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [DIV_C_W-1:0] cnt_q;
  logic [DIV_D_W-1:0] rem_q;
  logic [DIV_D_W-1:0] dsr_q;
  logic [DIV_Q_W-1:0] quo_q;

  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               fits;

  assign trial = {rem_q, quo_q[DIV_Q_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_C_W'(DIV_Q_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= DIV_D_W'(req_i.dividend[DIV_N_W-1:DIV_Q_W]);
      quo_q <= req_i.dividend[DIV_Q_W-1:0];
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      quo_q <= {quo_q[DIV_Q_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/rcfd_checker.sv =====
// rcfd_checker: port-level assertions for the frame decoder, bound to its top level
// depends on rcfd_pkg and robot_command_frame_decoder
module rcfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       frame_ok_o,
  input logic [3:0] action_o,
  input logic [9:0] code_value_o,
  input logic       stepper_direction_o,
  input logic [3:0] status_flags_o
);
  import rcfd_pkg::*;

  // rejected frame reports no action and a zero code
  a_bad_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_ok_o |-> action_o == ACT_NONE && code_value_o == '0)
    else $error("rejected frame with action or code");

  // direction only accompanies a stepper move
  a_dir_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stepper_direction_o |-> action_o == ACT_STEP_MOVE)
    else $error("direction set without stepper move");

  // a started move leaves the stepper busy
  a_move_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_STEP_MOVE |-> status_flags_o[3])
    else $error("stepper move without busy flag");

  // decoded code never exceeds three decimal digits
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> code_value_o <= 10'd999)
    else $error("code out of decimal range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(action_o)
                                    && $stable(code_value_o))
    else $error("result changed while stalled");

endmodule

bind robot_command_frame_decoder rcfd_checker u_rcfd_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .frame_ok_o          (frame_ok_o),
  .action_o            (action_o),
  .code_value_o        (code_value_o),
  .stepper_direction_o (stepper_direction_o),
  .status_flags_o      (status_flags_o)
);

// ===== tb/tb_robot_command_frame_decoder.sv =====
// tb_robot_command_frame_decoder: self-checking bench for the robot command frame decoder
// drives bytes and stepper-done items, programs registers over the apb port, and checks
// every frame report against a built-in predictor; depends on rcfd_pkg and the rtl only
module tb_robot_command_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import rcfd_pkg::*;

  // no item moves on any port for this long -> hung
  localparam int STUCK_LIMIT = 2000;
  // longest closing byte is a limit conversion through the shared divider
  localparam int DRAIN_CYCLES = 32;

  // every letter sum that selects an action
  localparam logic [18:0][7:0] ACTION_SUMS = {
    SUM_STEP_RIGHT, SUM_STEP_LEFT, SUM_STEP_CFG, SUM_SERVO_SET, SUM_SERVO_UP,
    SUM_SERVO_DN, SUM_DC_SET, SUM_DC_FWD, SUM_DC_BWD, SUM_STOP, SUM_TELEM,
    SUM_LIGHT, SUM_SUPPLY, SUM_CUR_LIM, SUM_SPD_LIM, SUM_OBST, SUM_LINK,
    SUM_RESET, SUM_HOST
  };

  // byte i of a frame sits at index i
  typedef logic [7:0][7:0] frame_t;

  typedef struct packed {
    logic         ok;
    rcfd_action_e action;
    logic [9:0]   code;
    logic         dir;
    logic [9:0]   servo;
    logic [9:0]   dc;
    logic         dc_en;
    logic [15:0]  cur_lim;
    logic [15:0]  spd_lim;
    logic [15:0]  obst_lvl;
    logic         radio;
    logic [3:0]   flags;
  } frame_report_t;

  // ---------------------------------------------------------------- dut signals
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        mode_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        frame_ok_o;
  logic [3:0]  action_o;
  logic [9:0]  code_value_o;
  logic        stepper_direction_o;
  logic [9:0]  servo_pulse_out_o;
  logic [9:0]  dc_pulse_out_o;
  logic        dc_enable_out_o;
  logic [15:0] current_limit_out_o;
  logic [15:0] speed_limit_out_o;
  logic [15:0] obstacle_level_out_o;
  logic        radio_link_out_o;
  logic [3:0]  status_flags_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  robot_command_frame_decoder u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .mode_i               (mode_i),
    .rx_byte_i            (rx_byte_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .frame_ok_o           (frame_ok_o),
    .action_o             (action_o),
    .code_value_o         (code_value_o),
    .stepper_direction_o  (stepper_direction_o),
    .servo_pulse_out_o    (servo_pulse_out_o),
    .dc_pulse_out_o       (dc_pulse_out_o),
    .dc_enable_out_o      (dc_enable_out_o),
    .current_limit_out_o  (current_limit_out_o),
    .speed_limit_out_o    (speed_limit_out_o),
    .obstacle_level_out_o (obstacle_level_out_o),
    .radio_link_out_o     (radio_link_out_o),
    .status_flags_o       (status_flags_o),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor state
  rcfd_cfg_t   cfg_shadow;
  logic [7:0]  frame_buf [8];
  logic [2:0]  byte_pos;
  logic [9:0]  servo_now, dc_now;
  logic        dc_on, busy_now, telem_on, light_on, supply_on, link_radio;
  logic [15:0] cur_lim, spd_lim, obst_lvl;

  frame_report_t frame_reports_q [$];

  // ---------------------------------------------------------------- run bookkeeping
  int  error_count = 0;
  int  items_sent = 0;
  int  reports_checked = 0;
  int  reg_writes = 0;
  int  stuck_cycles = 0;
  int  gap_pct = 10;      // chance of a sender gap before an item
  int  stall_pct = 10;    // chance of a receiver stall burst per cycle
  int  gap_calm_left = 0; // items left in a gap-free stretch
  int  done_pct = 0;      // chance of a stepper-done item inside a frame
  bit  no_idle = 1'b0;    // closing stretch: both sides run flat out

  function automatic void reset_model();
    cfg_shadow = '{servo_lo: RST_SERVO_LO, servo_hi: RST_SERVO_HI, servo_step: RST_SERVO_STP,
                   dc_neutral: RST_DC_NEU, dc_fwd: RST_DC_FWD, dc_bwd: RST_DC_BWD,
                   dc_offset: RST_DC_OFFS};
    foreach (frame_buf[i]) frame_buf[i] = '0;
    byte_pos   = '0;
    servo_now  = RST_SERVO;
    dc_now     = RST_DC_PULSE;
    dc_on      = 1'b0;
    busy_now   = 1'b0;
    telem_on   = 1'b0;
    light_on   = 1'b0;
    supply_on  = 1'b0;
    link_radio = 1'b1;
    cur_lim    = '0;
    spd_lim    = '0;
    obst_lvl   = '0;
  endfunction

  // ascii digit, anything else reads as zero
  function automatic int digit_value(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) ? int'(c) - int'(CH_ZERO) : 0;
  endfunction

  // forward / backward dc step, first step from neutral jumps by the start offset
  function automatic void step_dc(input bit forward);
    int neu, d;
    neu = int'(cfg_shadow.dc_neutral);
    if (int'(dc_now) == neu) begin
      d = forward ? neu - int'(cfg_shadow.dc_offset) : neu + int'(cfg_shadow.dc_offset);
    end else begin
      d = forward ? int'(dc_now) - 1 : int'(dc_now) + 1;
    end
    if (d == neu) begin
      dc_on = 1'b0;
    end else begin
      if (forward && d < int'(cfg_shadow.dc_fwd)) d = int'(cfg_shadow.dc_fwd);
      if (!forward && d > int'(cfg_shadow.dc_bwd)) d = int'(cfg_shadow.dc_bwd);
      dc_on = 1'b1;
    end
    dc_now = d[9:0];
  endfunction

  // advance the decoder by one accepted item, queue a report when a frame closes
  function automatic void decode_rx_item(input logic mode, input logic [7:0] rx);
    frame_report_t r;
    logic [7:0]    sum;
    int            code, s;
    if (mode) begin
      busy_now = 1'b0;
      return;
    end
    frame_buf[byte_pos] = rx;
    byte_pos = byte_pos + 3'd1;
    if (byte_pos != 3'd0) return;

    r = '0;
    r.action = ACT_NONE;
    if (frame_buf[POS_HEAD] == CH_HASH && frame_buf[POS_CR] == CH_CR &&
        frame_buf[POS_LF] == CH_LF) begin
      r.ok = 1'b1;
      sum = frame_buf[POS_L1] + frame_buf[POS_L2];
      if (frame_buf[POS_D1] == CH_DOT) begin
        code = digit_value(frame_buf[POS_D0]) * 10 + digit_value(frame_buf[POS_D2]);
      end else begin
        code = digit_value(frame_buf[POS_D0]) * 100 + digit_value(frame_buf[POS_D1]) * 10
             + digit_value(frame_buf[POS_D2]);
      end
      r.code = code[9:0];
      case (sum)
        SUM_STEP_RIGHT, SUM_STEP_LEFT: begin
          if (!busy_now) begin
            busy_now = 1'b1;
            r.action = ACT_STEP_MOVE;
            r.dir = (sum == SUM_STEP_RIGHT);
          end else begin
            r.action = ACT_STEP_BUSY;
          end
        end
        SUM_STEP_CFG: r.action = ACT_STEP_CFG;
        SUM_SERVO_SET: begin
          servo_now = code[9:0];
          r.action = ACT_SERVO;
        end
        SUM_SERVO_UP: begin
          s = int'(servo_now) + int'(cfg_shadow.servo_step);
          servo_now = (s > int'(cfg_shadow.servo_hi)) ? cfg_shadow.servo_hi : s[9:0];
          r.action = ACT_SERVO;
        end
        SUM_SERVO_DN: begin
          s = int'(servo_now) - int'(cfg_shadow.servo_step);
          servo_now = (s < int'(cfg_shadow.servo_lo)) ? cfg_shadow.servo_lo : s[9:0];
          r.action = ACT_SERVO;
        end
        SUM_DC_SET: begin
          dc_now = code[9:0];
          dc_on = (code[9:0] != cfg_shadow.dc_neutral);
          r.action = ACT_DC;
        end
        SUM_DC_FWD: begin
          step_dc(1'b1);
          r.action = ACT_DC;
        end
        SUM_DC_BWD: begin
          step_dc(1'b0);
          r.action = ACT_DC;
        end
        SUM_STOP: r.action = ACT_STOP;
        SUM_TELEM: begin
          telem_on = (code != 0);
          r.action = ACT_TELEM;
        end
        SUM_LIGHT: begin
          light_on = (code == int'(LIGHT_ON));
          r.action = ACT_LIGHT;
        end
        SUM_SUPPLY: begin
          supply_on = (code != 0);
          r.action = ACT_SUPPLY;
        end
        SUM_CUR_LIM: begin
          s = (code * int'(CUR_SCALE)) / int'(CONV_DIV);
          cur_lim = s[15:0];
          r.action = ACT_CUR_LIM;
        end
        SUM_SPD_LIM: begin
          // code zero would divide by zero, the limit saturates instead
          s = (code == 0) ? 65535 : int'(SPEED_NUM) / (int'(SPEED_SCALE) * code);
          spd_lim = s[15:0];
          r.action = ACT_SPD_LIM;
        end
        SUM_OBST: begin
          s = (code * int'(OBST_SCALE)) / int'(CONV_DIV);
          obst_lvl = s[15:0];
          r.action = ACT_OBST;
        end
        SUM_LINK: begin
          link_radio = (code != 0);
          r.action = ACT_LINK;
        end
        SUM_RESET: r.action = ACT_RESET;
        SUM_HOST: begin
          if (code == int'(HOST_SBC_A) || code == int'(HOST_SBC_B)) begin
            link_radio = 1'b0;
          end else if (code == int'(HOST_RADIO_A) || code == int'(HOST_RADIO_B)) begin
            link_radio = 1'b1;
          end
          r.action = ACT_HOST;
        end
        default: ;  // unknown sum: code still reported, nothing changes
      endcase
    end

    // report carries the state after the frame
    r.servo    = servo_now;
    r.dc       = dc_now;
    r.dc_en    = dc_on;
    r.cur_lim  = cur_lim;
    r.spd_lim  = spd_lim;
    r.obst_lvl = obst_lvl;
    r.radio    = link_radio;
    r.flags    = {busy_now, supply_on, light_on, telem_on};
    frame_reports_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      report_error($sformatf("report %0d %s: expected %0d, got %0d",
                             reports_checked, name, want, got));
    end
  endtask

  task automatic check_report(input frame_report_t want);
    compare_field("frame_ok",       want.ok,       frame_ok_o);
    compare_field("action",         want.action,   action_o);
    compare_field("code_value",     want.code,     code_value_o);
    compare_field("stepper_dir",    want.dir,      stepper_direction_o);
    compare_field("servo_pulse",    want.servo,    servo_pulse_out_o);
    compare_field("dc_pulse",       want.dc,       dc_pulse_out_o);
    compare_field("dc_enable",      want.dc_en,    dc_enable_out_o);
    compare_field("current_limit",  want.cur_lim,  current_limit_out_o);
    compare_field("speed_limit",    want.spd_lim,  speed_limit_out_o);
    compare_field("obstacle_level", want.obst_lvl, obstacle_level_out_o);
    compare_field("radio_link",     want.radio,    radio_link_out_o);
    compare_field("status_flags",   want.flags,    status_flags_o);
  endtask

  // every report taken is matched against the oldest pending frame
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_reports_q.size() == 0) begin
        report_error("frame report with no frame pending");
      end else begin
        check_report(frame_reports_q.pop_front());
      end
      reports_checked++;
    end
  end

  // watchdog: counts cycles in which no port moves anything
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("no progress for %0d cycles, %0d frames still pending",
               STUCK_LIMIT, frame_reports_q.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- report side back-pressure
  // random stall bursts, broken up by stretches with no stalls at all
  initial begin
    int stall_left, calm_left;
    stall_left = 0;
    calm_left = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (no_idle) begin
        stall_left = 0;
      end else if (stall_left == 0 && calm_left == 0) begin
        if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 13);
        else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 300);
      end
      out_ready_i <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
      if (calm_left > 0) calm_left--;
    end
  end

  // ---------------------------------------------------------------- input side
  // one item: optional gap, then valid held until accepted, prediction on acceptance
  task automatic send_item(input logic mode, input logic [7:0] rx);
    int gap;
    gap = 0;
    @(negedge clk_i);
    if (!no_idle && gap_calm_left == 0) begin
      if ($urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 13);
      else if ($urandom_range(0, 149) == 0) gap_calm_left = $urandom_range(40, 200);
    end
    if (gap_calm_left > 0) gap_calm_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    rx_byte_i  <= rx;
    do @(posedge clk_i); while (!in_ready_o);
    decode_rx_item(mode, rx);
    items_sent++;
  endtask

  // eight bytes, with the odd stepper-done item slipped in between
  task automatic send_frame(input frame_t f);
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 99) < done_pct) send_item(1'b1, 8'($urandom));
      send_item(1'b0, f[i]);
    end
  endtask

  // well-formed command; only the letter sum matters, so the split is random
  function automatic frame_t build_cmd(input logic [7:0] sum, input int code,
                                       input bit two_digit);
    frame_t f;
    f[POS_HEAD] = CH_HASH;
    f[POS_L1]   = 8'($urandom);
    f[POS_L2]   = sum - f[POS_L1];
    if (two_digit) begin
      f[POS_D0] = CH_ZERO + 8'((code / 10) % 10);
      f[POS_D1] = CH_DOT;
    end else begin
      f[POS_D0] = CH_ZERO + 8'(code / 100);
      f[POS_D1] = CH_ZERO + 8'((code / 10) % 10);
    end
    f[POS_D2] = CH_ZERO + 8'(code % 10);
    f[POS_CR] = CH_CR;
    f[POS_LF] = CH_LF;
    return f;
  endfunction

  task automatic send_command(input logic [7:0] sum, input int code,
                              input bit two_digit = 1'b0);
    send_frame(build_cmd(sum, code, two_digit));
  endtask

  // framing never resyncs: pad with noise until the byte counter wraps
  task automatic realign();
    while (byte_pos != 3'd0) send_item(1'b0, 8'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (frame_reports_q.size() != 0) @(posedge clk_i);
    // a stepper-done or mid-frame byte leaves no report to wait for
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- register port
  // write, then read back in a back-to-back transfer
  task automatic write_reg(input rcfd_reg_e r, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== value) begin
      report_error($sformatf("register %s read back %0d, wrote %0d", r.name(), prdata, value));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_SERVO_LO:  cfg_shadow.servo_lo   = value[PULSE_W-1:0];
      REG_SERVO_HI:  cfg_shadow.servo_hi   = value[PULSE_W-1:0];
      REG_SERVO_STP: cfg_shadow.servo_step = value[STEP_W-1:0];
      REG_DC_NEU:    cfg_shadow.dc_neutral = value[PULSE_W-1:0];
      REG_DC_FWD:    cfg_shadow.dc_fwd     = value[PULSE_W-1:0];
      REG_DC_BWD:    cfg_shadow.dc_bwd     = value[PULSE_W-1:0];
      REG_DC_OFFS:   cfg_shadow.dc_offset  = value[OFFS_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic program_regs(input int lo, input int hi, input int step, input int neu,
                              input int fwd, input int bwd, input int offs);
    write_reg(REG_SERVO_LO,  lo);
    write_reg(REG_SERVO_HI,  hi);
    write_reg(REG_SERVO_STP, step);
    write_reg(REG_DC_NEU,    neu);
    write_reg(REG_DC_FWD,    fwd);
    write_reg(REG_DC_BWD,    bwd);
    write_reg(REG_DC_OFFS,   offs);
  endtask

  // ---------------------------------------------------------------- random content
  function automatic logic [7:0] pick_sum();
    if ($urandom_range(0, 99) < 85) return ACTION_SUMS[$urandom_range(0, 18)];
    return 8'($urandom);
  endfunction

  function automatic int fit_code(input int v);
    return (v < 0) ? 0 : (v > 999) ? 999 : v;
  endfunction

  // codes biased toward the edges the actions care about
  function automatic int pick_code();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 9);
      1: return $urandom_range(0, 1) ? ($urandom_range(0, 1) ? int'(HOST_SBC_A) : 1)
                                     : ($urandom_range(0, 1) ? int'(HOST_RADIO_B) : 0);
      2: return fit_code(int'(cfg_shadow.dc_neutral) + $urandom_range(0, 2) - 1);
      3: return fit_code(($urandom_range(0, 1) ? int'(cfg_shadow.servo_hi)
                                               : int'(cfg_shadow.servo_lo))
                         + $urandom_range(0, 2) - 1);
      4: return $urandom_range(0, 1) ? 999 : 0;
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  // header and terminator checks, code forms, non-digits, letter extremes, misalignment
  task automatic test_frame_format();
    frame_t f;
    f = build_cmd(SUM_TELEM, 1, 1'b0);
    f[POS_HEAD] = 8'h24;             // bad header
    send_frame(f);
    f = build_cmd(SUM_TELEM, 1, 1'b0);
    f[POS_CR] = CH_LF;               // bad carriage return
    send_frame(f);
    f = build_cmd(SUM_TELEM, 1, 1'b0);
    f[POS_LF] = CH_CR;               // bad line feed
    send_frame(f);
    send_command(SUM_STOP, 999);
    send_command(SUM_STOP, 0);
    send_command(SUM_STEP_CFG, 99, 1'b1);   // two-digit form
    f = build_cmd(SUM_STEP_CFG, 0, 1'b0);
    f[POS_D0] = 8'hFF;               // non-digits read as zero
    f[POS_D1] = 8'h3A;
    f[POS_D2] = 8'h2F;
    send_frame(f);
    f = build_cmd(SUM_STEP_CFG, 0, 1'b1);
    f[POS_D0] = 8'h00;
    f[POS_D2] = 8'h7F;
    send_frame(f);
    f = build_cmd(SUM_STOP, 345, 1'b0);
    f[POS_L1] = 8'hFF;               // letters at max, sum wraps to an unknown value
    f[POS_L2] = 8'hFF;
    send_frame(f);
    f[POS_L1] = 8'h00;               // letters at zero, also unknown
    f[POS_L2] = 8'h00;
    send_frame(f);
    // stray byte pushes the next frame off its boundary
    send_item(1'b0, CH_HASH);
    send_command(SUM_STOP, 5);
    realign();
  endtask

  // move, move while busy, done item between frames and inside one, config
  task automatic test_stepper();
    frame_t f;
    send_command(SUM_STEP_RIGHT, 200);
    send_command(SUM_STEP_LEFT, 10);        // ignored, still busy
    send_item(1'b1, 8'hFF);
    send_command(SUM_STEP_LEFT, 10);
    f = build_cmd(SUM_STEP_RIGHT, 1, 1'b0);
    for (int i = 0; i < 4; i++) send_item(1'b0, f[i]);
    send_item(1'b1, 8'h00);                 // done mid-frame, byte counter untouched
    for (int i = 4; i < 8; i++) send_item(1'b0, f[i]);
    send_item(1'b1, 8'h5A);
    send_command(SUM_STEP_CFG, 123);
  endtask

  // servo set and clamped steps, dc set and stepping around neutral
  task automatic test_actuators();
    send_command(SUM_SERVO_SET, 173);
    send_command(SUM_SERVO_UP, 0);
    send_command(SUM_SERVO_UP, 0);          // clamps at high limit
    send_command(SUM_SERVO_SET, 107);
    send_command(SUM_SERVO_DN, 0);          // clamps at low limit
    send_command(SUM_SERVO_SET, 999);
    send_command(SUM_SERVO_DN, 0);
    send_command(SUM_DC_SET, 50);           // neutral disables
    send_command(SUM_DC_FWD, 0);            // jump off neutral
    repeat (8) send_command(SUM_DC_FWD, 0); // runs into the forward limit
    send_command(SUM_DC_BWD, 0);
    send_command(SUM_DC_SET, 50);
    send_command(SUM_DC_BWD, 0);
    send_command(SUM_DC_SET, 59);
    send_command(SUM_DC_BWD, 0);
    send_command(SUM_DC_BWD, 0);            // clamps at backward limit
    send_command(SUM_DC_SET, 51);
    send_command(SUM_DC_FWD, 0);            // lands on neutral, motor off
  endtask

  // flag setters and limit conversions, speed with code zero saturating
  task automatic test_flags_limits();
    send_command(SUM_TELEM, 1);
    send_command(SUM_TELEM, 0);
    send_command(SUM_LIGHT, 1);
    send_command(SUM_LIGHT, 2);
    send_command(SUM_SUPPLY, 7);
    send_command(SUM_SUPPLY, 0);
    send_command(SUM_CUR_LIM, 999);
    send_command(SUM_CUR_LIM, 0);
    send_command(SUM_SPD_LIM, 0);
    send_command(SUM_SPD_LIM, 1);
    send_command(SUM_SPD_LIM, 999);
    send_command(SUM_OBST, 999);
    send_command(SUM_OBST, 1);
    send_command(SUM_RESET, 0);
  endtask

  // link select and every host subcommand, plus one that changes nothing
  task automatic test_link_host();
    send_command(SUM_LINK, 0);
    send_command(SUM_LINK, 5);
    send_command(SUM_HOST, 111);
    send_command(SUM_HOST, 6);
    send_command(SUM_HOST, 1, 1'b1);
    send_command(SUM_HOST, 0);
    send_command(SUM_HOST, 50);
  endtask

  // mostly well-formed commands, some broken frames, noise bursts and done items
  task automatic test_random_traffic(input int n_items);
    int     target, last_pick, pick;
    frame_t f;
    target = items_sent + n_items;
    last_pick = items_sent;
    done_pct = 3;
    while (items_sent < target) begin
      if (!no_idle && items_sent - last_pick > 150) begin
        gap_pct   = $urandom_range(0, 2) * 15;
        stall_pct = $urandom_range(0, 2) * 15;
        last_pick = items_sent;
      end
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        f = build_cmd(pick_sum(), pick_code(), $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) f[POS_D0 + $urandom_range(0, 2)] = 8'($urandom);
        send_frame(f);
      end else if (pick < 87) begin
        f = build_cmd(pick_sum(), pick_code(), 1'b0);
        f[$urandom_range(0, 7)] = 8'($urandom);
        send_frame(f);
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 12)) send_item(1'b0, 8'($urandom));
        realign();
      end else begin
        repeat ($urandom_range(1, 3)) send_item(1'b1, 8'($urandom));
      end
    end
    done_pct = 0;
  endtask

  // register extremes, a realistic wide range, a random pick, then defaults again
  task automatic test_register_settings();
    for (int s = 0; s < 5; s++) begin
      wait_drained();
      case (s)
        0: program_regs(0, 0, 1, 0, 0, 0, 0);
        1: program_regs(1023, 1023, 63, 1023, 1023, 1023, 15);
        2: program_regs(0, 1023, 63, 512, 0, 1023, 15);
        3: program_regs($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(1, 63), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 15));
        default: program_regs(RST_SERVO_LO, RST_SERVO_HI, RST_SERVO_STP, RST_DC_NEU,
                              RST_DC_FWD, RST_DC_BWD, RST_DC_OFFS);
      endcase
      test_random_traffic(170);
    end
  endtask

  // closing stretch with both sides running flat out
  task automatic test_quiet_tail();
    no_idle = 1'b1;
    gap_pct = 0;
    stall_pct = 0;
    test_random_traffic(200);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    in_valid_i  = 1'b0;
    mode_i      = 1'b0;
    rx_byte_i   = 8'h00;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    rst_ni      = 1'b0;
    reset_model();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values written back and read out while idle
    program_regs(RST_SERVO_LO, RST_SERVO_HI, RST_SERVO_STP, RST_DC_NEU,
                 RST_DC_FWD, RST_DC_BWD, RST_DC_OFFS);

    test_frame_format();
    test_stepper();
    test_actuators();
    test_flags_limits();
    test_link_host();
    test_random_traffic(300);
    test_register_settings();
    test_quiet_tail();
    wait_drained();

    if (frame_reports_q.size() != 0) begin
      report_error($sformatf("%0d frames never reported", frame_reports_q.size()));
    end
    $display("drove %0d bytes and stepper-done items, checked %0d frame reports",
             items_sent, reports_checked);
    $display("%0d register writes over 6 settings, %0d mismatches", reg_writes, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== robot_command_frame_decoder.f =====
rtl/rcfd_pkg.sv
rtl/rcfd_cfg.sv
rtl/rcfd_div.sv
rtl/robot_command_frame_decoder.sv
rtl/rcfd_checker.sv
tb/tb_robot_command_frame_decoder.sv
